>>> hdl/six_channel_compare_overflow_timer_macros.svh
// Assertion macros shared by the timer block; empty under synthesis.
`ifndef SIX_CHANNEL_COMPARE_OVERFLOW_TIMER_MACROS_SVH
`define SIX_CHANNEL_COMPARE_OVERFLOW_TIMER_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define SCCT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer block check failed");
// Antecedent implies consequent in the next cycle.
`define SCCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer block check failed");
`else
`define SCCT_ASSERT_SAME(label, ante, cons)
`define SCCT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hdl/scct_pkg.sv
// Types, constants and helper functions of the six-channel timer block.
package scct_pkg;

    localparam int NUM_TIMERS = 6;
    localparam int COUNT_W    = 33;
    localparam int WORK_W     = 34;

    typedef logic [2:0] timer_id_t;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [3:0] REG_COUNT  = 4'h0;
    localparam logic [3:0] REG_MODE   = 4'h4;
    localparam logic [3:0] REG_TARGET = 4'h8;

    localparam int MB_CLR_ON_IRQ = 3;
    localparam int MB_CMP_IRQ    = 4;
    localparam int MB_OVF_IRQ    = 5;
    localparam int MB_REP_IRQ    = 6;
    localparam int MB_LEVL       = 7;
    localparam int MB_USE_EXT    = 8;
    localparam int MB_IRQ_EN     = 10;
    localparam int MB_CMP_FLAG   = 11;
    localparam int MB_OVF_FLAG   = 12;
    localparam int MB_T4_PRE     = 13;

    localparam logic [15:0] MODE_KEEP     = 16'h1c00;
    localparam logic [15:0] MODE_WRITABLE = 16'he3ff;
    localparam logic [15:0] MODE_IRQ_EN   = 16'h0400;
    localparam logic [15:0] MODE_FLAGS    = 16'h1800;

    localparam logic [7:0] EXT_PERIOD = 8'd91;
    localparam logic [7:0] PRE_PERIOD = 8'd129;

    typedef struct packed {
        logic        tick;
        logic        rd_mode;
        logic        wr_count;
        logic        wr_mode;
        logic        wr_target;
        logic [31:0] data;
    } timer_cmd_t;

    typedef struct packed {
        logic       hit;
        timer_id_t  idx;
        logic [3:0] reg_code;
    } bus_sel_t;

    function automatic logic [7:0] base_page(input timer_id_t id);
        logic [7:0] page;
        case (id)
            3'd0:    page = 8'h10;
            3'd1:    page = 8'h11;
            3'd2:    page = 8'h12;
            3'd3:    page = 8'h48;
            3'd4:    page = 8'h49;
            3'd5:    page = 8'h4a;
            default: page = 8'h00;
        endcase
        return page;
    endfunction

    function automatic logic is_wide(input timer_id_t id);
        return id >= 3'd3;
    endfunction

    function automatic logic slow_clock(input timer_id_t id, input logic [15:0] mode);
        return (id == 3'd1 && mode[MB_USE_EXT]) || (id == 3'd4 && mode[MB_T4_PRE]);
    endfunction

    function automatic logic [7:0] period_of(input timer_id_t id, input logic [15:0] mode);
        logic [7:0] p;
        if (!slow_clock(id, mode))
        begin
            p = 8'd1;
        end
        else if (id == 3'd1)
        begin
            p = EXT_PERIOD;
        end
        else
        begin
            p = PRE_PERIOD;
        end
        return p;
    endfunction

    // Interrupt side effect on irq_en: one-shot clears it, repeat-plus-level toggles it, repeat alone keeps it.
    function automatic logic [15:0] fire_update(input logic [15:0] mode);
        logic [15:0] m;
        m = mode;
        if (!m[MB_REP_IRQ])
        begin
            m[MB_IRQ_EN] = 1'b0;
        end
        else if (m[MB_LEVL])
        begin
            m[MB_IRQ_EN] = ~m[MB_IRQ_EN];
        end
        return m;
    endfunction

endpackage

>>> hdl/scct_if.sv
// Valid/ready channel interfaces for bus/tick requests and responses.
interface scct_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [11:0] address;
    logic [31:0] write_data;

    modport source (output valid, output operation, output address, output write_data,
                    input ready);
    modport sink   (input valid, input operation, input address, input write_data,
                    output ready);
endinterface

interface scct_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [5:0]  irq_lines;

    modport source (output valid, output read_data, output irq_lines, input ready);
    modport sink   (input valid, input read_data, input irq_lines, output ready);
endinterface

>>> hdl/scct_decode.sv
// Address decode: turns one transaction into per-timer commands and a read select.
module scct_decode
    import scct_pkg::*;
(
    input  logic                         en,
    input  logic [1:0]                   operation,
    input  logic [11:0]                  address,
    input  logic [31:0]                  write_data,
    output timer_cmd_t [NUM_TIMERS-1:0]  cmds,
    output bus_sel_t                     sel
);

    logic reg_ok;

    assign reg_ok = (address[3:0] == REG_COUNT) || (address[3:0] == REG_MODE)
                 || (address[3:0] == REG_TARGET);

    always_comb
    begin
        sel.hit      = 1'b0;
        sel.idx      = '0;
        sel.reg_code = address[3:0];
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (address[11:4] == base_page(timer_id_t'(i)) && reg_ok)
            begin
                sel.hit = 1'b1;
                sel.idx = timer_id_t'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            cmds[i].tick      = en && (operation == OP_TICK);
            cmds[i].rd_mode   = 1'b0;
            cmds[i].wr_count  = 1'b0;
            cmds[i].wr_mode   = 1'b0;
            cmds[i].wr_target = 1'b0;
            cmds[i].data      = write_data;
            if (en && sel.hit && sel.idx == timer_id_t'(i))
            begin
                cmds[i].rd_mode   = (operation == OP_READ)  && (sel.reg_code == REG_MODE);
                cmds[i].wr_count  = (operation == OP_WRITE) && (sel.reg_code == REG_COUNT);
                cmds[i].wr_mode   = (operation == OP_WRITE) && (sel.reg_code == REG_MODE);
                cmds[i].wr_target = (operation == OP_WRITE) && (sel.reg_code == REG_TARGET);
            end
        end
    end

endmodule

>>> hdl/scct_timer.sv
// One timer channel: counter, target, mode word and prescaler with compare/overflow.
module scct_timer
    import scct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  timer_id_t   timer_id,
    input  timer_cmd_t  cmd,
    output logic [31:0] count_lo,
    output logic [31:0] target,
    output logic [15:0] mode,
    output logic        irq
);

    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [31:0]        target_reg, target_next;
    logic [15:0]        mode_reg,   mode_next;
    logic [7:0]         presc_reg,  presc_next;

    logic [WORK_W-1:0]  work_count;
    logic [WORK_W-1:0]  limit;
    logic [15:0]        work_mode;
    logic [15:0]        wr_mode_val;
    logic               fire_cmp;
    logic               fire_ovf;
    logic               zeroed;

    assign limit = is_wide(timer_id) ? WORK_W'(34'h0_ffff_ffff) : WORK_W'(34'h0_0000_ffff);
    assign wr_mode_val = (mode_reg & MODE_KEEP) | MODE_IRQ_EN | (cmd.data[15:0] & MODE_WRITABLE);

    always_comb
    begin
        count_next  = count_reg;
        target_next = target_reg;
        mode_next   = mode_reg;
        presc_next  = presc_reg;
        work_count  = {1'b0, count_reg};
        work_mode   = mode_reg;
        fire_cmp    = 1'b0;
        fire_ovf    = 1'b0;
        zeroed      = 1'b0;

        if (cmd.tick)
        begin
            if (presc_reg > 8'd1)
            begin
                presc_next = presc_reg - 8'd1;
            end
            else
            begin
                presc_next = period_of(timer_id, mode_reg);
                work_count = {1'b0, count_reg}
                           + (slow_clock(timer_id, mode_reg) ? WORK_W'(1) : WORK_W'(2));
                // compare first, then overflow on what is left
                if (work_count >= {2'b00, target_reg} && count_reg[31:0] < target_reg)
                begin
                    work_mode[MB_CMP_FLAG] = 1'b1;
                    if (work_mode[MB_CMP_IRQ] && work_mode[MB_IRQ_EN])
                    begin
                        fire_cmp  = 1'b1;
                        work_mode = fire_update(work_mode);
                        if (work_mode[MB_CLR_ON_IRQ])
                        begin
                            work_count = '0;
                        end
                    end
                end
                if (work_count > limit)
                begin
                    work_mode[MB_OVF_FLAG] = 1'b1;
                    if (work_mode[MB_OVF_IRQ] && work_mode[MB_IRQ_EN])
                    begin
                        fire_ovf  = 1'b1;
                        work_mode = fire_update(work_mode);
                        if (work_mode[MB_CLR_ON_IRQ])
                        begin
                            zeroed     = 1'b1;
                            work_count = '0;
                        end
                    end
                    if (!zeroed)
                    begin
                        work_count = work_count - (limit + WORK_W'(1));
                    end
                end
                count_next = work_count[COUNT_W-1:0];
                mode_next  = work_mode;
            end
        end
        else if (cmd.rd_mode)
        begin
            mode_next = mode_reg & ~MODE_FLAGS;
        end
        else if (cmd.wr_count)
        begin
            count_next = {1'b0, cmd.data};
        end
        else if (cmd.wr_target)
        begin
            target_next = cmd.data;
            if (!mode_reg[MB_LEVL])
            begin
                mode_next[MB_IRQ_EN] = 1'b1;
            end
        end
        else if (cmd.wr_mode)
        begin
            count_next = '0;
            mode_next  = wr_mode_val;
            presc_next = period_of(timer_id, wr_mode_val);
            if (target_reg == '0)
            begin
                mode_next[MB_CMP_FLAG] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            target_reg <= '0;
            mode_reg   <= '0;
            presc_reg  <= 8'd1;
        end
        else
        begin
            count_reg  <= count_next;
            target_reg <= target_next;
            mode_reg   <= mode_next;
            presc_reg  <= presc_next;
        end
    end

    assign count_lo = count_reg[31:0];
    assign target   = target_reg;
    assign mode     = mode_reg;
    assign irq      = fire_cmp | fire_ovf;

endmodule

>>> hdl/six_channel_compare_overflow_timer.sv
// Six-channel compare/overflow timer: top level with input stage, timers and result register.
// A transaction accepted into the input stage moves to the output register once that
// register is free or being drained; rsp.valid is then raised from the output register.
// One transaction per cycle without stalls; ticks update all six timers in the same cycle.
// Reset: counters, targets and mode words clear, prescalers load 1, both stages empty.
`include "six_channel_compare_overflow_timer_macros.svh"
module six_channel_compare_overflow_timer
    import scct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    scct_req_if.sink    req,
    scct_rsp_if.source  rsp
);

    logic        s1_valid_reg;
    logic [1:0]  s1_op_reg;
    logic [11:0] s1_addr_reg;
    logic [31:0] s1_data_reg;
    logic        s1_adv;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] rd_reg,        rd_next;
    logic [5:0]  irq_reg;

    timer_cmd_t [NUM_TIMERS-1:0] cmds;
    bus_sel_t                    dec_sel;
    logic [31:0]                 count_lo [NUM_TIMERS];
    logic [31:0]                 target   [NUM_TIMERS];
    logic [15:0]                 mode     [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]       irq_vec;

    // advance the input stage whenever the result slot is free or being drained
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_op_reg   <= req.operation;
            s1_addr_reg <= req.address;
            s1_data_reg <= req.write_data;
        end
    end

    scct_decode u_decode
    (
        .en         (s1_adv),
        .operation  (s1_op_reg),
        .address    (s1_addr_reg),
        .write_data (s1_data_reg),
        .cmds       (cmds),
        .sel        (dec_sel)
    );

    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_timer
        scct_timer u_timer
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .timer_id (timer_id_t'(i)),
            .cmd      (cmds[i]),
            .count_lo (count_lo[i]),
            .target   (target[i]),
            .mode     (mode[i]),
            .irq      (irq_vec[i])
        );
    end

    always_comb
    begin
        rd_next = '0;
        if (s1_op_reg == OP_READ && dec_sel.hit)
        begin
            unique case (dec_sel.reg_code)
                REG_COUNT:  rd_next = count_lo[dec_sel.idx];
                REG_TARGET: rd_next = target[dec_sel.idx];
                REG_MODE:   rd_next = {16'h0000, mode[dec_sel.idx]};
                default:    rd_next = '0;
            endcase
        end
    end

    assign out_valid_next = s1_adv || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            rd_reg  <= rd_next;
            irq_reg <= irq_vec;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = rd_reg;
    assign rsp.irq_lines = irq_reg;

    `SCCT_ASSERT_NEXT(a_irq_only_on_tick, s1_adv && s1_op_reg != OP_TICK, irq_reg == '0)
    `SCCT_ASSERT_NEXT(a_data_only_on_read, s1_adv && s1_op_reg != OP_READ, rd_reg == '0)
    `SCCT_ASSERT_NEXT(a_mode_write_clears, s1_adv && s1_op_reg == OP_WRITE && dec_sel.hit && dec_sel.reg_code == REG_MODE, count_lo[$past(dec_sel.idx)] == '0)
    `SCCT_ASSERT_SAME(a_no_advance_when_blocked, out_valid_reg && !rsp.ready, !s1_adv)

endmodule
